// File: rtl/core/edh_pkg.sv
// Shared types, constants and arithmetic helpers of the error diffusion halftoner.
package edh_pkg;

  localparam int LINE_MAX_DEF = 1024;

  localparam int PIX_W   = 8;
  localparam int LW_W    = 11;
  localparam int THR_W   = 8;
  localparam int ERR_W   = 11;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 1;

  localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 11'd256;
  localparam logic [THR_W-1:0] THRESHOLD_RST  = 8'd128;

  localparam logic [CIDX_W-1:0] CFG_LINE_WIDTH = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_THRESHOLD  = 1'b1;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 11'sh3FF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 11'sh400;

  localparam logic signed [11:0] WHITE_LEVEL = 12'sd255;

  // Diffusion weights, all over sixteen.
  localparam logic signed [14:0] W_RIGHT      = 15'sd7;
  localparam logic signed [14:0] W_BELOW      = 15'sd5;
  localparam logic signed [14:0] W_BELOW_LEFT = 15'sd3;

  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic valid;
    logic frame_start;
    logic last;
    logic first_line;
    logic fwd_hit;
  } s1_ctrl_t;

  function automatic err_t sat11(input logic signed [13:0] v);
    err_t r;
    if (v > 14'sd1023) begin
      r = ERR_MAX;
    end else if (v < -14'sd1024) begin
      r = ERR_MIN;
    end else begin
      r = err_t'(v);
    end
    return r;
  endfunction

  // Division by sixteen that truncates toward zero.
  function automatic err_t div16(input logic signed [14:0] v);
    logic signed [14:0] b;
    b = v + $signed({11'd0, {4{v[14]}}});
    return err_t'(b >>> 4);
  endfunction

endpackage

// File: rtl/core/error_diffusion_halftone_core.sv
// Top level of the Floyd-Steinberg error diffusion halftoner.
//
// Grey pixels enter in raster order on the in_ channel (valid/ready), with
// in_frame_start set on the first pixel of each frame. Each pixel gives one
// result on the out_ channel: out_white and out_line_end on the last pixel of
// a line. Line width and threshold are set through the cfg_ write port; the user
// must write them only while no transaction is in flight, as the core does not enforce it.
// Each accepted pixel is registered in the input register while the previous
// line's error is read from the line store (a single-port-write RAM of LINE_MAX
// entries with registered read); the threshold and diffusion adds follow, and the
// result goes into the output register. One pixel is accepted every cycle while
// the receiver keeps up; the right-hand error is carried from pixel to pixel in the diffusion stage.
// Reset clears the carried errors and the column count and marks the first
// line of a frame; the line store is not cleared, as the first line reads zero.
// When the receiver stalls, the result is held in the output register and one
// more pixel may be taken into the input register before in_ready falls.
module error_diffusion_halftone_core #(
  parameter int LINE_MAX = edh_pkg::LINE_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [edh_pkg::PIX_W-1:0]    in_pixel,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_white,
  output logic                         out_line_end,
  input  logic                         cfg_we,
  input  logic [edh_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [edh_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW = $clog2(LINE_MAX);

  logic [edh_pkg::LW_W-1:0]  line_width_r;
  logic [edh_pkg::THR_W-1:0] threshold_r;

  logic                      s1_adv;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  edh_pkg::err_t             mem_wdata;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  edh_pkg::err_t             mem_rdata;
  edh_pkg::s1_ctrl_t         s1_ctrl;
  logic [edh_pkg::PIX_W-1:0] s1_pixel;
  logic [AW-1:0]             s1_x;
  edh_pkg::err_t             s1_fwd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= edh_pkg::LINE_WIDTH_RST;
      threshold_r  <= edh_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        edh_pkg::CFG_LINE_WIDTH: line_width_r <= cfg_data[edh_pkg::LW_W-1:0];
        edh_pkg::CFG_THRESHOLD:  threshold_r  <= cfg_data[edh_pkg::THR_W-1:0];
      endcase
    end
  end

  edh_front #(
    .LINE_MAX (LINE_MAX),
    .AW       (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .line_width     (line_width_r),
    .s1_adv         (s1_adv),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .s1_ctrl        (s1_ctrl),
    .s1_pixel       (s1_pixel),
    .s1_x           (s1_x),
    .s1_fwd_data    (s1_fwd_data)
  );

  edh_line_store #(
    .DEPTH (LINE_MAX),
    .AW    (AW)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rd_en (rd_en),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  edh_diffuse #(
    .LINE_MAX (LINE_MAX),
    .AW       (AW)
  ) u_diffuse (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_ctrl      (s1_ctrl),
    .s1_pixel     (s1_pixel),
    .s1_x         (s1_x),
    .s1_fwd_data  (s1_fwd_data),
    .mem_rdata    (mem_rdata),
    .threshold    (threshold_r),
    .s1_adv       (s1_adv),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_white    (out_white),
    .out_line_end (out_line_end)
  );

endmodule

// File: rtl/core/edh_line_store.sv
// Line store holding the diffused errors for the next image line.
module edh_line_store #(
  parameter int DEPTH = edh_pkg::LINE_MAX_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  edh_pkg::err_t      wdata,
  input  logic               rd_en,
  input  logic [AW-1:0]      raddr,
  output edh_pkg::err_t      rdata
);

  edh_pkg::err_t mem [DEPTH];
  edh_pkg::err_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/edh_front.sv
// Input stage: column and first-line tracking, line store read issue and the pixel register.
module edh_front #(
  parameter int LINE_MAX = edh_pkg::LINE_MAX_DEF,
  parameter int AW       = $clog2(LINE_MAX)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [edh_pkg::PIX_W-1:0]   in_pixel,
  input  logic                        in_frame_start,
  input  logic [edh_pkg::LW_W-1:0]    line_width,
  input  logic                        s1_adv,
  input  logic                        mem_we,
  input  logic [AW-1:0]               mem_waddr,
  input  edh_pkg::err_t               mem_wdata,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  output edh_pkg::s1_ctrl_t           s1_ctrl,
  output logic [edh_pkg::PIX_W-1:0]   s1_pixel,
  output logic [AW-1:0]               s1_x,
  output edh_pkg::err_t               s1_fwd_data
);

  localparam int WW   = $clog2(LINE_MAX + 1);
  localparam int CMPW = (WW > edh_pkg::LW_W) ? WW : edh_pkg::LW_W;

  logic [AW-1:0]     col_r, col_nxt;
  logic              first_r, first_nxt;
  logic              accept;
  logic [AW-1:0]     x_acc;
  logic              fl_acc;
  logic              last_acc;
  logic [CMPW-1:0]   lw_ext;
  logic [CMPW-1:0]   w_eff;

  edh_pkg::s1_ctrl_t             ctrl_r, ctrl_nxt;
  logic [edh_pkg::PIX_W-1:0]     pixel_r;
  logic [AW-1:0]                 x_r;
  edh_pkg::err_t                 fwd_data_r;

  assign in_ready = !ctrl_r.valid || s1_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lw_ext = CMPW'(line_width);
    if (lw_ext < CMPW'(2)) begin
      w_eff = CMPW'(2);
    end else if (lw_ext > CMPW'(LINE_MAX)) begin
      w_eff = CMPW'(LINE_MAX);
    end else begin
      w_eff = lw_ext;
    end
    x_acc    = in_frame_start ? '0 : col_r;
    fl_acc   = in_frame_start || first_r;
    last_acc = CMPW'(x_acc) >= (w_eff - CMPW'(1));

    col_nxt   = col_r;
    first_nxt = first_r;
    if (accept) begin
      col_nxt   = last_acc ? '0 : x_acc + AW'(1);
      first_nxt = last_acc ? 1'b0 : fl_acc;
    end

    ctrl_nxt = ctrl_r;
    if (accept) begin
      ctrl_nxt.valid       = 1'b1;
      ctrl_nxt.frame_start = in_frame_start;
      ctrl_nxt.last        = last_acc;
      ctrl_nxt.first_line  = fl_acc;
      // A write landing on the same entry at this edge is taken over directly.
      ctrl_nxt.fwd_hit     = mem_we && (mem_waddr == x_acc);
    end else if (s1_adv) begin
      ctrl_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
      ctrl_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_r    <= in_pixel;
      x_r        <= x_acc;
      fwd_data_r <= mem_wdata;
    end
  end

  assign rd_en       = accept;
  assign rd_addr     = x_acc;
  assign s1_ctrl     = ctrl_r;
  assign s1_pixel    = pixel_r;
  assign s1_x        = x_r;
  assign s1_fwd_data = fwd_data_r;

endmodule

// File: rtl/core/edh_diffuse.sv
// Threshold and error diffusion stage with carried errors, line store writes and output register.
module edh_diffuse #(
  parameter int LINE_MAX = edh_pkg::LINE_MAX_DEF,
  parameter int AW       = $clog2(LINE_MAX)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  edh_pkg::s1_ctrl_t           s1_ctrl,
  input  logic [edh_pkg::PIX_W-1:0]   s1_pixel,
  input  logic [AW-1:0]               s1_x,
  input  edh_pkg::err_t               s1_fwd_data,
  input  edh_pkg::err_t               mem_rdata,
  input  logic [edh_pkg::THR_W-1:0]   threshold,
  output logic                        s1_adv,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output edh_pkg::err_t               mem_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_white,
  output logic                        out_line_end
);

  edh_pkg::err_t rc_r, rc_nxt;
  edh_pkg::err_t bp_r, bp_nxt;
  edh_pkg::err_t brp_r, brp_nxt;
  logic          tail_pend_r;
  logic [AW-1:0] tail_addr_r;
  edh_pkg::err_t tail_data_r;
  logic          out_valid_r;
  logic          out_white_r;
  logic          out_line_end_r;

  edh_pkg::err_t      rc_eff, bp_eff, brp_eff, above;
  logic signed [13:0] sum_raw;
  edh_pkg::err_t      sum;
  logic               white;
  logic signed [11:0] err;
  edh_pkg::err_t      e7, e5, e3, e1;
  edh_pkg::err_t      below_val, below_left_val;

  assign s1_adv = s1_ctrl.valid && (!out_valid_r || out_ready);

  always_comb begin
    // A frame start clears the carried errors before this pixel uses them.
    rc_eff  = s1_ctrl.frame_start ? '0 : rc_r;
    bp_eff  = s1_ctrl.frame_start ? '0 : bp_r;
    brp_eff = s1_ctrl.frame_start ? '0 : brp_r;
    if (s1_ctrl.first_line) begin
      above = '0;
    end else if (s1_ctrl.fwd_hit) begin
      above = s1_fwd_data;
    end else begin
      above = mem_rdata;
    end

    sum_raw = $signed({6'd0, s1_pixel}) + 14'(rc_eff) + 14'(above);
    sum     = edh_pkg::sat11(sum_raw);
    white   = sum >= $signed({3'd0, threshold});
    err     = 12'(sum) - (white ? edh_pkg::WHITE_LEVEL : 12'sd0);

    e7 = edh_pkg::div16(15'(err) * edh_pkg::W_RIGHT);
    e5 = edh_pkg::div16(15'(err) * edh_pkg::W_BELOW);
    e3 = edh_pkg::div16(15'(err) * edh_pkg::W_BELOW_LEFT);
    e1 = edh_pkg::div16(15'(err));

    below_left_val = edh_pkg::sat11(14'(bp_eff) + 14'(e3));
    below_val      = edh_pkg::sat11(14'(brp_eff) + 14'(e5));

    rc_nxt  = rc_r;
    bp_nxt  = bp_r;
    brp_nxt = brp_r;
    if (s1_adv) begin
      if (s1_ctrl.last) begin
        rc_nxt  = '0;
        bp_nxt  = '0;
        brp_nxt = '0;
      end else begin
        rc_nxt  = e7;
        bp_nxt  = below_val;
        brp_nxt = e1;
      end
    end

    // The last column's entry is written from registers in the following cycle; the pixel that follows a line
    // end sits in column zero and writes nothing, so the port is free then.
    if (tail_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = tail_addr_r;
      mem_wdata = tail_data_r;
    end else begin
      mem_we    = s1_adv && (s1_x != '0);
      mem_waddr = s1_x - AW'(1);
      mem_wdata = below_left_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= '0;
      bp_r        <= '0;
      brp_r       <= '0;
      tail_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rc_r        <= rc_nxt;
      bp_r        <= bp_nxt;
      brp_r       <= brp_nxt;
      tail_pend_r <= s1_adv && s1_ctrl.last;
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      tail_addr_r    <= s1_x;
      tail_data_r    <= below_val;
      out_white_r    <= white;
      out_line_end_r <= s1_ctrl.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_white    = out_white_r;
  assign out_line_end = out_line_end_r;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the Floyd-Steinberg error diffusion halftone core.
module testbench;

  typedef struct packed {
    logic white;
    logic line_end;
  } dot_t;

  // Tracks the diffused errors of the core and checks each output dot in order.
  class dot_scoreboard;
    int            span;
    int            level;
    edh_pkg::err_t line_store [edh_pkg::LINE_MAX_DEF];
    int            carry_right;
    int            carry_below;
    int            carry_below_right;
    int            column;
    bit            top_row;
    dot_t          expected_dots [$];
    int unsigned   dots_seen;
    int unsigned   faults;

    function new();
      span      = int'(edh_pkg::LINE_WIDTH_RST);
      level     = int'(edh_pkg::THRESHOLD_RST);
      top_row   = 1'b1;
      dots_seen = 0;
      faults    = 0;
      clear_carries();
    endfunction

    function void clear_carries();
      carry_right       = 0;
      carry_below       = 0;
      carry_below_right = 0;
      column            = 0;
    endfunction

    function int clip11(int v);
      if (v > 1023) return 1023;
      if (v < -1024) return -1024;
      return v;
    endfunction

    function void report(string msg);
      faults++;
      if (faults <= 10) $display("mismatch: %s", msg);
    endfunction

    function void write_reg(logic [edh_pkg::CIDX_W-1:0] idx,
                            logic [edh_pkg::CFG_W-1:0] data);
      if (idx == edh_pkg::CFG_LINE_WIDTH) begin
        span = int'(data);
      end else if (idx == edh_pkg::CFG_THRESHOLD) begin
        level = int'(data[edh_pkg::THR_W-1:0]);
      end
    endfunction

    // Works out the dot for one accepted pixel transaction and moves the errors on.
    function void diffuse_pixel(logic [edh_pkg::PIX_W-1:0] grey, logic fs);
      int   w;
      int   x;
      int   above;
      int   total;
      int   err;
      int   e7;
      int   e5;
      int   e3;
      int   e1;
      bit   white;
      bit   last;
      dot_t dot;
      w = span;
      if (w < 2) w = 2;
      if (w > edh_pkg::LINE_MAX_DEF) w = edh_pkg::LINE_MAX_DEF;
      if (fs) begin
        clear_carries();
        top_row = 1'b1;
      end
      x = column;
      if (x >= edh_pkg::LINE_MAX_DEF) x = edh_pkg::LINE_MAX_DEF - 1;
      last  = (x >= w - 1);
      above = top_row ? 0 : int'(line_store[x]);
      total = clip11(int'(grey) + carry_right + above);
      white = (total >= level);
      err   = total - (white ? 255 : 0);
      // Signed division truncates toward zero, as the stencil requires.
      e7 = (7 * err) / 16;
      e5 = (5 * err) / 16;
      e3 = (3 * err) / 16;
      e1 = err / 16;
      if (x >= 1) line_store[x - 1] = edh_pkg::err_t'(clip11(carry_below + e3));
      if (last) begin
        line_store[x] = edh_pkg::err_t'(clip11(carry_below_right + e5));
        clear_carries();
        top_row = 1'b0;
      end else begin
        carry_below       = clip11(carry_below_right + e5);
        carry_below_right = e1;
        carry_right       = e7;
        column            = x + 1;
      end
      dot.white    = white;
      dot.line_end = last;
      expected_dots.push_back(dot);
    endfunction

    function void check_dot(logic white, logic line_end);
      dot_t want;
      dots_seen++;
      if (expected_dots.size() == 0) begin
        report($sformatf("result %0d arrived with no pixel outstanding", dots_seen));
      end else begin
        want = expected_dots.pop_front();
        if (white !== want.white || line_end !== want.line_end) begin
          report($sformatf("result %0d: expected white=%0b line_end=%0b, got white=%0b line_end=%0b",
                           dots_seen, want.white, want.line_end, white, line_end));
        end
      end
    endfunction

    function void finish_check();
      if (expected_dots.size() != 0) begin
        report($sformatf("%0d results never arrived", expected_dots.size()));
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [edh_pkg::PIX_W-1:0]   in_pixel;
  logic                        in_frame_start;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_white;
  logic                        out_line_end;
  logic                        cfg_we;
  logic [edh_pkg::CIDX_W-1:0]  cfg_index;
  logic [edh_pkg::CFG_W-1:0]   cfg_data;

  dot_scoreboard sb;
  int            tx_run_left = 0;
  bit            tx_eager    = 1'b0;

  error_diffusion_halftone_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_white      (out_white),
    .out_line_end   (out_line_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Valid is left high on return, so a back-to-back transaction never drops it.
  task automatic send_pixel(input logic [edh_pkg::PIX_W-1:0] grey, input logic fs);
    int gap;
    if (tx_run_left == 0) begin
      tx_run_left = 40;
      tx_eager    = ($urandom_range(0, 3) == 0);
    end
    tx_run_left--;
    gap = tx_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= grey;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    sb.diffuse_pixel(grey, fs);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_dots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(input int unsigned w_data, input int unsigned t_data);
    cfg_we    <= 1'b1;
    cfg_index <= edh_pkg::CFG_LINE_WIDTH;
    cfg_data  <= edh_pkg::CFG_W'(w_data);
    @(posedge clk);
    sb.write_reg(edh_pkg::CFG_LINE_WIDTH, edh_pkg::CFG_W'(w_data));
    cfg_index <= edh_pkg::CFG_THRESHOLD;
    cfg_data  <= edh_pkg::CFG_W'(t_data);
    @(posedge clk);
    sb.write_reg(edh_pkg::CFG_THRESHOLD, edh_pkg::CFG_W'(t_data));
    cfg_we <= 1'b0;
  endtask

  // A new setting always opens a new frame, so a wider line never reads a stale store.
  task automatic run_phase(input int unsigned w_data, input int unsigned t_data,
                           input int count, input bit noisy);
    int                        eff_w;
    int                        col;
    int                        style;
    int                        base;
    logic [edh_pkg::PIX_W-1:0] grey;
    bit                        fs;
    wait_drained();
    set_registers(w_data, t_data);
    eff_w = (w_data < 2) ? 2 :
            (w_data > edh_pkg::LINE_MAX_DEF) ? edh_pkg::LINE_MAX_DEF : int'(w_data);
    col   = 0;
    style = 0;
    base  = 0;
    for (int n = 0; n < count; n++) begin
      fs = (n == 0) || (noisy && $urandom_range(0, 79) == 0);
      if (fs) col = 0;
      if (col == 0) begin
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, 255);
      end
      unique case (style)
        0: grey = edh_pkg::PIX_W'($urandom_range(0, 255));
        1: grey = edh_pkg::PIX_W'(base);
        2: grey = edh_pkg::PIX_W'(base + col * 5);
        default: grey = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      endcase
      send_pixel(grey, fs);
      col = (col + 1 >= eff_w) ? 0 : col + 1;
      if (noisy && $urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  initial begin : result_sink
    int stall;
    int run_left;
    bit eager;
    run_left = 0;
    eager    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (run_left == 0) begin
        run_left = 40;
        eager    = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      stall = eager ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_dot(out_white, out_line_end);
    end
  end

  initial begin : stimulus
    int budget;
    int unsigned w_data;
    int unsigned t_data;
    int          pick;
    int          count;
    sb = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel       <= '0;
    in_frame_start <= 1'b0;
    out_ready      <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= edh_pkg::CFG_LINE_WIDTH;
    cfg_data       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // A width below two behaves as two; threshold zero lets any non-negative sum go white.
    set_registers(0, 0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    wait_drained();

    set_registers(5, 255);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd64, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    wait_drained();

    // Narrowing the line part way through makes the next pixel the last one.
    set_registers(8, 1);
    send_pixel(8'd10, 1'b1);
    send_pixel(8'd250, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd90, 1'b0);
    wait_drained();
    set_registers(3, 1);
    send_pixel(8'd77, 1'b0);
    send_pixel(8'd180, 1'b0);
    send_pixel(8'd33, 1'b0);
    send_pixel(8'd221, 1'b0);

    // One full line at the widest setting, then a few pixels reading it back.
    run_phase(11'd2047, $urandom_range(1, 255), edh_pkg::LINE_MAX_DEF + 8, 1'b0);

    budget = 0;
    while (budget < 850) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) w_data = $urandom_range(0, 1);
      else if (pick == 1) w_data = 2;
      else if (pick <= 7) w_data = $urandom_range(3, 16);
      else w_data = $urandom_range(17, 96);
      pick = $urandom_range(0, 5);
      if (pick == 0) t_data = 0;
      else if (pick == 1) t_data = 1;
      else if (pick == 2) t_data = 255;
      else t_data = $urandom_range(2, 254);
      t_data = t_data | ($urandom_range(0, 7) << edh_pkg::THR_W);
      count  = $urandom_range(40, 160);
      run_phase(w_data, t_data, count, 1'b1);
      budget += count;
    end

    wait_drained();
    sb.finish_check();
    if (sb.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: error_diffusion_halftone_core.f
rtl/core/edh_pkg.sv
rtl/core/edh_line_store.sv
rtl/core/edh_front.sv
rtl/core/edh_diffuse.sv
rtl/core/error_diffusion_halftone_core.sv
tb/testbench.sv
